### rtl/bsd_pkg.sv
// shared constants, types and register map for the box signed distance core
// no dependencies
package bsd_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 16;
    localparam int HALF_W     = 15;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = COORD_W;
    localparam int EXC_W      = COORD_W + 2;
    localparam int SQR_W      = 2 * MAG_W;
    localparam int SUM_W      = SQR_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int TRIAL_W    = SUM_W + 1;
    localparam int DIST_W     = EXC_W;
    localparam int SQRT_STAGES = ROOT_W;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1 << FRAC_BITS);

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HALF_X   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HALF_Y   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HALF_Z   = 3'd5;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] center;
        logic [NUM_AXES-1:0][HALF_W-1:0]  half;
    } bsd_cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic signed [EXC_W-1:0] mx;
        logic                    outside;
    } bsd_front_t;

    typedef struct packed {
        logic [SUM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [EXC_W-1:0] mx;
        logic                    outside;
    } bsd_sqrt_t;

endpackage

### rtl/bsd_regs.sv
// apb register file for box centre and half extents
// depends on bsd_pkg
module bsd_regs
    import bsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output bsd_cfg_t              cfg
);

    bsd_cfg_t              cfg_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                cfg_reg.center[a] <= '0;
                cfg_reg.half[a]   <= HALF_RESET;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CENTER_X: cfg_reg.center[0] <= pwdata[COORD_W-1:0];
                REG_CENTER_Y: cfg_reg.center[1] <= pwdata[COORD_W-1:0];
                REG_CENTER_Z: cfg_reg.center[2] <= pwdata[COORD_W-1:0];
                REG_HALF_X:   cfg_reg.half[0]   <= pwdata[HALF_W-1:0];
                REG_HALF_Y:   cfg_reg.half[1]   <= pwdata[HALF_W-1:0];
                REG_HALF_Z:   cfg_reg.half[2]   <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = APB_DATA_W'($signed(cfg_reg.center[0]));
            REG_CENTER_Y: prdata = APB_DATA_W'($signed(cfg_reg.center[1]));
            REG_CENTER_Z: prdata = APB_DATA_W'($signed(cfg_reg.center[2]));
            REG_HALF_X:   prdata = APB_DATA_W'(cfg_reg.half[0]);
            REG_HALF_Y:   prdata = APB_DATA_W'(cfg_reg.half[1]);
            REG_HALF_Z:   prdata = APB_DATA_W'(cfg_reg.half[2]);
            default:      prdata = '0;
        endcase
    end

endmodule

### rtl/bsd_front.sv
// four-stage front end: offset, axis excess, squares and max, sum of squares
// depends on bsd_pkg
module bsd_front
    import bsd_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bsd_cfg_t                           cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [NUM_AXES-1:0][COORD_W-1:0]   in_point,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bsd_front_t                         out_data
);

    logic [3:0] v_reg;
    logic [4:0] stall_chain;

    logic signed [DIFF_W-1:0] diff_reg [NUM_AXES];
    logic signed [EXC_W-1:0]  exc_reg  [NUM_AXES];
    logic [SQR_W-1:0]         sq_reg   [NUM_AXES];
    logic signed [EXC_W-1:0]  mx3_reg;
    bsd_front_t               res_reg;

    logic signed [DIFF_W-1:0] diff_next [NUM_AXES];
    logic signed [EXC_W-1:0]  exc_next  [NUM_AXES];
    logic [SQR_W-1:0]         sq_next   [NUM_AXES];
    logic signed [EXC_W-1:0]  mx3_next;
    bsd_front_t               res_next;
    logic [MAG_W-1:0]         mag [NUM_AXES];
    logic [MAG_W-1:0]         pos [NUM_AXES];
    logic signed [EXC_W-1:0]  mx01;

    assign stall_chain[4] = out_stall;
    assign stall_chain[3] = v_reg[3] && stall_chain[4];
    assign stall_chain[2] = v_reg[2] && stall_chain[3];
    assign stall_chain[1] = v_reg[1] && stall_chain[2];
    assign stall_chain[0] = v_reg[0] && stall_chain[1];
    assign in_stall  = stall_chain[0];
    assign out_valid = v_reg[3];
    assign out_data  = res_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff_next[a] = DIFF_W'($signed(in_point[a])) - DIFF_W'($signed(cfg.center[a]));
            mag[a] = diff_reg[a][DIFF_W-1] ? MAG_W'(-diff_reg[a]) : MAG_W'(diff_reg[a]);
            exc_next[a] = $signed({2'b00, mag[a]}) - $signed({3'b000, cfg.half[a]});
            pos[a] = (exc_reg[a] > 0) ? exc_reg[a][MAG_W-1:0] : '0;
            sq_next[a] = pos[a] * pos[a];
        end
        mx01     = (exc_reg[1] > exc_reg[0]) ? exc_reg[1] : exc_reg[0];
        mx3_next = (exc_reg[2] > mx01) ? exc_reg[2] : mx01;
        res_next.sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        res_next.mx  = mx3_reg;
        res_next.outside = (mx3_reg > 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (!stall_chain[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (!stall_chain[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (!stall_chain[2])
            begin
                v_reg[2] <= v_reg[1];
            end
            if (!stall_chain[3])
            begin
                v_reg[3] <= v_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_chain[0])
        begin
            diff_reg <= diff_next;
        end
        if (!stall_chain[1])
        begin
            exc_reg <= exc_next;
        end
        if (!stall_chain[2])
        begin
            sq_reg  <= sq_next;
            mx3_reg <= mx3_next;
        end
        if (!stall_chain[3])
        begin
            res_reg <= res_next;
        end
    end

    // the sum is non-zero exactly when some axis lies outside
    a_outside_sum: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> (res_reg.outside == (res_reg.sum != '0)))
        else $error("outside flag disagrees with sum of squares");

endmodule

### rtl/bsd_sqrt.sv
// pipelined floor square root, one root bit per stage
// depends on bsd_pkg
module bsd_sqrt
    import bsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  bsd_front_t in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output bsd_sqrt_t  out_data
);

    logic [SQRT_STAGES-1:0] v_reg;
    logic [SQRT_STAGES:0]   stall_chain;
    bsd_sqrt_t              stg_reg [SQRT_STAGES];
    bsd_sqrt_t              src     [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] src_v;

    assign stall_chain[SQRT_STAGES] = out_stall;
    assign in_stall  = stall_chain[0];
    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_data  = stg_reg[SQRT_STAGES-1];

    assign src[0].rem     = in_data.sum;
    assign src[0].root    = '0;
    assign src[0].mx      = in_data.mx;
    assign src[0].outside = in_data.outside;
    assign src_v[0]       = in_valid;

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;

        logic [TRIAL_W-1:0] trial;
        logic               take;
        bsd_sqrt_t          stg_next;

        if (k > 0)
        begin : g_link
            assign src[k]   = stg_reg[k-1];
            assign src_v[k] = v_reg[k-1];
        end

        assign stall_chain[k] = v_reg[k] && stall_chain[k+1];

        always_comb
        begin
            trial = (TRIAL_W'(src[k].root) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
            take  = (TRIAL_W'(src[k].rem) >= trial);
            stg_next = src[k];
            if (take)
            begin
                stg_next.rem  = src[k].rem - SUM_W'(trial);
                stg_next.root = src[k].root | (ROOT_W'(1) << BIT);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (!stall_chain[k])
            begin
                v_reg[k] <= src_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!stall_chain[k])
            begin
                stg_reg[k] <= stg_next;
            end
        end
    end

    // floor root: remainder never exceeds twice the root
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[SQRT_STAGES-1] |->
            (stg_reg[SQRT_STAGES-1].rem <= (SUM_W'(stg_reg[SQRT_STAGES-1].root) << 1)))
        else $error("square root remainder out of range");

    // an inside item reaches the end with nothing left to root
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[SQRT_STAGES-1] && !stg_reg[SQRT_STAGES-1].outside) |->
            (stg_reg[SQRT_STAGES-1].root == '0))
        else $error("inside item carries a non-zero root");

endmodule

### rtl/box_signed_distance_core.sv
// top level of the box signed distance core: registers, front end, root, output register
// depends on bsd_pkg, bsd_regs, bsd_front, bsd_sqrt
//
// channel   direction  handshake                   payload
// point     in         point_valid / point_stall   point_x, point_y, point_z
// distance  out        distance_valid / distance_stall  distance
// apb       in/out     psel, penable, pready       paddr, pwdata, prdata
//
// one item per cycle sustained while distance_stall stays low
// each item passes the 4 front stages, 17 root-bit stages and the output register
// reset clears all valid bits and loads centre 0 and half extent 1.0 on every axis
// a stall only holds stages that carry an item, so empty stages keep filling
module box_signed_distance_core
    import bsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  point_valid,
    output logic                  point_stall,
    input  logic [COORD_W-1:0]    point_x,
    input  logic [COORD_W-1:0]    point_y,
    input  logic [COORD_W-1:0]    point_z,
    output logic                  distance_valid,
    input  logic                  distance_stall,
    output logic [DIST_W-1:0]     distance
);

    bsd_cfg_t                       cfg;
    logic [NUM_AXES-1:0][COORD_W-1:0] point;
    logic                           front_valid;
    logic                           front_stall;
    bsd_front_t                     front_data;
    logic                           root_valid;
    logic                           root_stall;
    bsd_sqrt_t                      root_data;
    logic                           dist_valid_reg;
    logic [DIST_W-1:0]              dist_reg;
    logic [DIST_W-1:0]              dist_next;
    logic                           out_hold;

    assign point[0] = point_x;
    assign point[1] = point_y;
    assign point[2] = point_z;

    bsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (point_valid),
        .in_stall  (point_stall),
        .in_point  (point),
        .out_valid (front_valid),
        .out_stall (front_stall),
        .out_data  (front_data)
    );

    bsd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_stall  (front_stall),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_stall (root_stall),
        .out_data  (root_data)
    );

    assign out_hold   = dist_valid_reg && distance_stall;
    assign root_stall = out_hold;
    assign dist_next  = root_data.outside ? DIST_W'(root_data.root) : DIST_W'(root_data.mx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_valid_reg <= 1'b0;
        end
        else if (!out_hold)
        begin
            dist_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_hold)
        begin
            dist_reg <= dist_next;
        end
    end

    assign distance_valid = dist_valid_reg;
    assign distance       = dist_reg;

    // with the output free the whole pipe moves, so no item is refused
    a_no_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        !out_hold |-> !point_stall)
        else $error("input stalled while the output is free");

    // a held result keeps its value until taken
    a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_hold) |-> (dist_valid_reg && $stable(dist_reg)))
        else $error("held item changed");

endmodule
